FILE: src/smrs_pkg.sv
// ----------------------------------------------------------------------------
// smrs_pkg
// Types and constants shared by the serial message to radio splitter.
// ----------------------------------------------------------------------------
package smrs_pkg;

  localparam int unsigned MsgBytes  = 16;
  localparam int unsigned PosW      = $clog2(MsgBytes);
  localparam int unsigned HalfBytes = MsgBytes / 2;
  localparam int unsigned PktW      = 8 * HalfBytes;

  localparam logic [7:0] HDR_A     = 8'h41;
  localparam logic [7:0] HDR_B     = 8'h42;
  localparam logic [7:0] HDR_C     = 8'h43;
  localparam logic [7:0] TERM_BYTE = 8'h0D;
  localparam logic [7:0] PAD_BYTE  = 8'h20;

  localparam logic [PosW-1:0] POS_START   = PosW'(0);
  localparam logic [PosW-1:0] POS_BODY    = PosW'(1);
  localparam logic [PosW-1:0] POS_HALF    = PosW'(HalfBytes - 1);
  localparam logic [PosW-1:0] POS_SECOND  = PosW'(HalfBytes);
  localparam logic [PosW-1:0] POS_LAST    = PosW'(MsgBytes - 1);

  typedef struct packed {
    logic [7:0]      header_code;
    logic [3:0]      body_length;
    logic            message_end;
    logic            second_half;
    logic [PktW-1:0] packet_bytes;
    logic            packet_valid;
  } result_t;

endpackage

FILE: src/serial_message_to_radio_splitter_top.sv
// ----------------------------------------------------------------------------
// serial_message_to_radio_splitter_top
// Path: an accepted byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle while the output is not back-pressured; the state update is one short pass.
// Reset: position and half-sent flag clear, both registers empty; the
// message buffer is not reset.
// ----------------------------------------------------------------------------
module serial_message_to_radio_splitter_top
  import smrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [0] packet_valid, [64:1] packet_bytes,
                                      // [68:65] body_length, [76:69] header_code
  output logic        m_axis_tlast,   // message_end
  output logic        m_axis_tuser    // second_half
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       advance, res_vld;
  result_t    res, out_res;

  assign advance       = in_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  smrs_assembler u_asm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  smrs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_vld),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.header_code, out_res.body_length,
                         out_res.packet_bytes, out_res.packet_valid};
  assign m_axis_tlast = out_res.message_end;
  assign m_axis_tuser = out_res.second_half;

endmodule

FILE: src/smrs_assembler.sv
// ----------------------------------------------------------------------------
// smrs_assembler
// Message buffer, position tracking and packet/terminator result logic.
// ----------------------------------------------------------------------------
module smrs_assembler
  import smrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_vld_o,
  output result_t    res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            fhs_q, fhs_d;
  logic [7:0]      buf_q [MsgBytes];
  logic [7:0]      buf_d [MsgBytes];

  logic is_hdr, is_term, sendable, half;
  logic send, ends;

  assign is_hdr   = (byte_i == HDR_A) || (byte_i == HDR_B) || (byte_i == HDR_C);
  assign is_term  = (pos_q != POS_START) && (pos_q != POS_BODY) && (byte_i == TERM_BYTE);
  assign sendable = (buf_q[0] == HDR_B) || (buf_q[0] == HDR_C);

  always_comb begin
    for (int k = 0; k < MsgBytes; k++) begin
      buf_d[k] = buf_q[k];
      if (PosW'(k) == pos_q) begin
        buf_d[k] = byte_i;
      end else if (is_term && (PosW'(k) > pos_q)) begin
        buf_d[k] = PAD_BYTE;
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    fhs_d = fhs_q;
    send  = 1'b0;
    ends  = 1'b0;
    half  = 1'b0;
    if (pos_q == POS_START) begin
      fhs_d = 1'b0;
      pos_d = is_hdr ? POS_BODY : POS_START;
    end else if (is_term) begin
      ends  = 1'b1;
      send  = sendable;
      half  = fhs_q;
      pos_d = POS_START;
    end else if (pos_q == POS_HALF) begin
      if (!fhs_q) begin
        fhs_d = 1'b1;
        pos_d = POS_SECOND;
        send  = sendable;
      end
    end else if (pos_q == POS_LAST) begin
      pos_d = POS_START;
      send  = sendable;
      half  = 1'b1;
    end else begin
      pos_d = pos_q + POS_BODY;
    end
  end

  always_comb begin
    res_o = '0;
    res_o.header_code  = buf_q[0];
    res_o.packet_valid = send;
    res_o.second_half  = send & half;
    res_o.message_end  = ends;
    res_o.body_length  = ends ? 4'(pos_q - POS_BODY) : 4'd0;
    if (send) begin
      for (int k = 0; k < HalfBytes; k++) begin
        res_o.packet_bytes[8*k +: 8] = half ? buf_d[HalfBytes + k] : buf_d[k];
      end
    end
  end

  assign res_vld_o = send | ends;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_START;
      fhs_q <= 1'b0;
    end else if (step_i) begin
      pos_q <= pos_d;
      fhs_q <= fhs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      buf_q <= buf_d;
    end
  end

endmodule

FILE: src/smrs_out_reg.sv
// ----------------------------------------------------------------------------
// smrs_out_reg
// Result register holding one result until the downstream transfer.
// ----------------------------------------------------------------------------
module smrs_out_reg
  import smrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  always_comb begin
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

FILE: test/serial_message_to_radio_splitter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_message_to_radio_splitter_top_tb
// Streams serial bytes into the splitter: framed messages under each header,
// early terminators, full sixteen-byte frames and stray bytes. Random gaps
// and back-pressure are applied on both sides. A local model of the
// assembler predicts every packet and message-end record, and each output
// transfer is checked field by field, in order.
// ----------------------------------------------------------------------------
module serial_message_to_radio_splitter_top_tb;
  import smrs_pkg::*;

  localparam int RandomBytes  = 1250;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 10;
  localparam int ReportLimit  = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  serial_message_to_radio_splitter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Assembler state
  logic [PosW-1:0] msg_pos = POS_START;
  logic            lo_half_done = 1'b0;
  logic [7:0]      msg_buf [MsgBytes];

  logic [7:0] rx_bytes [$];
  result_t    expected_results [$];

  int bytes_driven = 0;
  int packets_seen = 0;
  int ends_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  function automatic int pick_delay(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic bit header_sends();
    return msg_buf[0] == HDR_B || msg_buf[0] == HDR_C;
  endfunction

  function automatic result_t packet_result(input bit upper);
    result_t r;
    int base;
    r = '0;
    base = upper ? HalfBytes : 0;
    for (int k = 0; k < HalfBytes; k++) r.packet_bytes[8*k +: 8] = msg_buf[base + k];
    r.packet_valid = 1'b1;
    r.second_half = upper;
    r.header_code = msg_buf[0];
    return r;
  endfunction

  task automatic assemble_byte(input logic [7:0] rx);
    result_t r;
    if (msg_pos == POS_START) begin
      msg_buf[0] = rx;
      lo_half_done = 1'b0;
      if (rx == HDR_A || rx == HDR_B || rx == HDR_C) msg_pos = POS_BODY;
    end else if (rx == TERM_BYTE && msg_pos > POS_BODY) begin
      msg_buf[msg_pos] = rx;
      for (int k = int'(msg_pos) + 1; k < MsgBytes; k++) msg_buf[k] = PAD_BYTE;
      if (header_sends()) begin
        r = packet_result(lo_half_done);
      end else begin
        r = '0;
        r.header_code = msg_buf[0];
      end
      r.message_end = 1'b1;
      r.body_length = 4'(msg_pos - 1);
      expected_results.push_back(r);
      msg_pos = POS_START;
    end else begin
      msg_buf[msg_pos] = rx;
      if (msg_pos == POS_HALF) begin
        if (!lo_half_done) begin
          lo_half_done = 1'b1;
          msg_pos = POS_SECOND;
          if (header_sends()) expected_results.push_back(packet_result(1'b0));
        end
      end else if (msg_pos == POS_LAST) begin
        msg_pos = POS_START;
        if (header_sends()) expected_results.push_back(packet_result(1'b1));
      end else begin
        msg_pos = msg_pos + 1'b1;
      end
    end
  endtask

  task automatic queue_message(input logic [7:0] hdr, input int body_len, input bit closed);
    rx_bytes.push_back(hdr);
    for (int i = 0; i < body_len; i++) rx_bytes.push_back(8'($urandom));
    if (closed) rx_bytes.push_back(TERM_BYTE);
  endtask

  // Byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        assemble_byte(s_axis_tdata);
        bytes_driven++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes.size() > 0) begin
          s_axis_tdata <= rx_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
          tx_wait = pick_delay(tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.packet_valid = m_axis_tdata[0];
        got.packet_bytes = m_axis_tdata[64:1];
        got.body_length = m_axis_tdata[68:65];
        got.header_code = m_axis_tdata[76:69];
        got.message_end = m_axis_tlast;
        got.second_half = m_axis_tuser;
        if (got.packet_valid === 1'b1) packets_seen++;
        if (got.message_end === 1'b1) ends_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: unexpected result pv=%b bytes=%h half=%b end=%b len=%0d hdr=%h",
                     $realtime, got.packet_valid, got.packet_bytes, got.second_half,
                     got.message_end, got.body_length, got.header_code);
        end else begin
          want = expected_results.pop_front();
          if (got.packet_valid !== want.packet_valid ||
              got.packet_bytes !== want.packet_bytes ||
              got.second_half !== want.second_half ||
              got.message_end !== want.message_end ||
              got.body_length !== want.body_length ||
              got.header_code !== want.header_code) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: mismatch", $realtime);
              $display("  exp pv=%b bytes=%h half=%b end=%b len=%0d hdr=%h",
                       want.packet_valid, want.packet_bytes, want.second_half,
                       want.message_end, want.body_length, want.header_code);
              $display("  got pv=%b bytes=%h half=%b end=%b len=%0d hdr=%h",
                       got.packet_valid, got.packet_bytes, got.second_half,
                       got.message_end, got.body_length, got.header_code);
            end
          end
        end
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        rx_wait = pick_delay(rx_calm);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    logic [7:0] hdr;
    bit closed;

    // stray bytes at frame start
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    // silent header; CR right after the header is body, second CR ends it
    rx_bytes.push_back(HDR_A);
    rx_bytes.push_back(TERM_BYTE);
    rx_bytes.push_back(TERM_BYTE);
    // terminator on the last byte of the first half
    rx_bytes.push_back(HDR_B);
    rx_bytes.push_back(TERM_BYTE);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(8'h55);
    rx_bytes.push_back(8'hAA);
    rx_bytes.push_back(PAD_BYTE);
    rx_bytes.push_back(TERM_BYTE);
    // full frame, both packets
    rx_bytes.push_back(HDR_C);
    for (int i = 1; i < MsgBytes; i++) rx_bytes.push_back(i[0] ? 8'hFF : 8'h00);

    while (rx_bytes.size() < RandomBytes) begin
      pick = $urandom_range(0, 9);
      hdr = (pick % 3 == 0) ? HDR_A : (pick % 3 == 1) ? HDR_B : HDR_C;
      if (pick == 0) begin
        for (int i = $urandom_range(1, 4); i > 0; i--) rx_bytes.push_back(8'($urandom));
      end else if (pick == 1) begin
        queue_message(hdr, $urandom_range(0, 6), 1'b0);
      end else begin
        closed = $urandom_range(0, 3) != 0;
        queue_message(hdr, closed ? $urandom_range(1, 14) : MsgBytes - 1, closed);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_bytes.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("drove %0d bytes; checked %0d packets and %0d message ends",
             bytes_driven, packets_seen, ends_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: serial_message_to_radio_splitter_top.f
src/smrs_pkg.sv
src/smrs_assembler.sv
src/smrs_out_reg.sv
src/serial_message_to_radio_splitter_top.sv
test/serial_message_to_radio_splitter_top_tb.sv
